>>> rtl/pser_pkg.sv
// Package for the per-slave event ring: shared widths, parameter defaults
// and the request, result and register codes. No dependencies.
`default_nettype none
package pser_pkg;

	// Parameter defaults for the top level.
	localparam int SLAVE_CNT_DEF  = 8;
	localparam int RING_DEPTH_DEF = 8;

	// Fixed field widths.
	localparam int PTR_W     = 16;
	localparam int ENTRY_W   = 48;
	localparam int PARAM_W   = 32;
	localparam int CODE_W    = 8;
	localparam int MASK_W    = 8;
	localparam int VALUE_W   = 64;
	localparam int KIND_W    = 2;
	localparam int SLAVE_W   = 3;
	localparam int CFG_IDX_W = 2;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_POST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BCAST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GET   = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] RES_ENTRY    = 2'd0;
	localparam logic [KIND_W-1:0] RES_EMPTY    = 2'd1;
	localparam logic [KIND_W-1:0] RES_OVERFLOW = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE_CODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_CODE = 2'd2;

endpackage
`default_nettype wire

>>> rtl/pser_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Uses no package; contents are undefined until written.
`default_nettype none
module pser_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/pser_slot_rem.sv
// Slot index unit: remainder of a 16-bit ring pointer by the ring depth.
// Depends on pser_pkg for the pointer width.
`default_nettype none
module pser_slot_rem #(
	parameter int RING_DEPTH = pser_pkg::RING_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire  [pser_pkg::PTR_W-1:0]     value,
	output logic                           done,
	output logic [$clog2(RING_DEPTH)-1:0]  rem
);

	localparam int RD_W    = $clog2(RING_DEPTH);
	localparam bit IS_POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
	// The reciprocal of the depth, scaled by 2^SHIFT and rounded up, gives the
	// exact quotient of any 16-bit pointer after the product is shifted down.
	localparam int SHIFT   = pser_pkg::PTR_W + RD_W;
	localparam int RECIP_W = pser_pkg::PTR_W + 1;
	localparam int PROD_W  = pser_pkg::PTR_W + RECIP_W;
	localparam longint RECIP_L =
		((longint'(1) << SHIFT) + longint'(RING_DEPTH) - 1) / longint'(RING_DEPTH);
	localparam logic [RECIP_W-1:0]         RECIP   = RECIP_W'(RECIP_L);
	localparam logic [pser_pkg::PTR_W-1:0] DIVISOR = pser_pkg::PTR_W'(RING_DEPTH);

	logic                       mul_q;
	logic                       sub_q;
	logic                       done_q;
	logic [pser_pkg::PTR_W-1:0] val_q;
	logic [PROD_W-1:0]          prod_q;
	logic [pser_pkg::PTR_W-1:0] quot;
	logic [pser_pkg::PTR_W-1:0] diff;
	logic [RD_W-1:0]            acc_q;

	// Quotient from the scaled product, then the remainder by one multiply back.
	assign quot = pser_pkg::PTR_W'(prod_q >> SHIFT);
	assign diff = val_q - quot * DIVISOR;

	// A power-of-two depth is a plain mask and is ready in the cycle after start;
	// any other depth takes a multiply step and a subtract step on top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			sub_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			mul_q  <= start && !IS_POW2;
			sub_q  <= !start && mul_q;
			done_q <= start ? IS_POW2 : sub_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			if (IS_POW2) begin
				acc_q <= value[RD_W-1:0];
			end
		end else if (mul_q) begin
			prod_q <= PROD_W'(val_q) * PROD_W'(RECIP);
		end else if (sub_q) begin
			acc_q <= RD_W'(diff);
		end
	end

	assign done = done_q;
	assign rem  = acc_q;

endmodule
`default_nettype wire

>>> rtl/per_slave_event_ring.sv
// Per-slave event ring: top level with the sequencer, pointer store and entry store.
// Depends on pser_pkg, pser_ram and pser_slot_rem.
`default_nettype none
// The block keeps one overwrite-oldest event ring of RING_DEPTH entries for
// each of SLAVE_CNT slaves, with a 16-bit producer and consumer pointer per
// ring. A post word stores type, port and parameter at the producer slot of
// one active slave and advances its producer; a broadcast does so for every
// active slave in ascending order; neither returns a result. A get returns
// the oldest pending entry, the empty code, or the overflow code (in which
// case the consumer jumps to producer minus RING_DEPTH). Items are handled
// one at a time by a small sequencer around two RAMs (pointers, entries) and
// a slot index unit. With a power-of-two RING_DEPTH a post occupies the block
// after acceptance for pointer read, pointer use and slot index, and a get
// for pointer read, pointer use, slot index, entry read and result hand-off;
// a get that answers empty or overflow skips the slot index and entry read.
// The result hand-off waits while the output register still holds an
// unaccepted word. The slot index unit adds a multiply and a subtract step
// to each ring access when RING_DEPTH is not a power of two. A broadcast
// scans every slave in turn and runs the post steps for each active slave.
// Input is taken again as soon as the sequencer is idle, even while the
// previous result word still waits in the output register. Entry storage
// is not cleared at reset; pointers read as zero until first written.
module per_slave_event_ring #(
	parameter int SLAVE_CNT  = pser_pkg::SLAVE_CNT_DEF,
	parameter int RING_DEPTH = pser_pkg::RING_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// Request channel.
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [pser_pkg::KIND_W-1:0]        kind,
	input  wire  [pser_pkg::SLAVE_W-1:0]       slave,
	input  wire  [pser_pkg::CODE_W-1:0]        event_type,
	input  wire  [pser_pkg::CODE_W-1:0]        port,
	input  wire  [pser_pkg::PARAM_W-1:0]       param,
	// Result channel.
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [pser_pkg::KIND_W-1:0]        result_kind,
	output logic [pser_pkg::VALUE_W-1:0]       out_value,
	// Configuration write channel.
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [pser_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [pser_pkg::CODE_W-1:0]        cfg_data
);

	localparam int PTR_W     = pser_pkg::PTR_W;
	localparam int SLV_W     = SLAVE_CNT > 1 ? $clog2(SLAVE_CNT) : 1;
	localparam int RD_W      = $clog2(RING_DEPTH);
	localparam int ENT_DEPTH = SLAVE_CNT * RING_DEPTH;
	localparam int ENT_AW    = $clog2(ENT_DEPTH);
	localparam int WIDE_W    = 7;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BC   = 3'd1;
	localparam logic [2:0] S_PRD  = 3'd2;
	localparam logic [2:0] S_PUSE = 3'd3;
	localparam logic [2:0] S_REM  = 3'd4;
	localparam logic [2:0] S_ERD  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]                     state_q;
	logic [2:0]                     state_d;

	// Configuration registers.
	logic [pser_pkg::MASK_W-1:0]    mask_q;
	logic [pser_pkg::CODE_W-1:0]    none_q;
	logic [pser_pkg::CODE_W-1:0]    ovf_q;

	// Latched request.
	logic [pser_pkg::KIND_W-1:0]    kind_q;
	logic [SLV_W-1:0]               cur_q;
	logic [pser_pkg::CODE_W-1:0]    type_q;
	logic [pser_pkg::CODE_W-1:0]    port_q;
	logic [pser_pkg::PARAM_W-1:0]   param_q;

	// Pointers of the slave being worked on.
	logic [PTR_W-1:0]               prod_q;
	logic [PTR_W-1:0]               cons_q;
	logic [SLAVE_CNT-1:0]           ptr_vld_q;

	// Pending result and output register.
	logic [pser_pkg::KIND_W-1:0]    res_kind_q;
	logic [pser_pkg::VALUE_W-1:0]   res_val_q;
	logic                           out_valid_q;
	logic [pser_pkg::KIND_W-1:0]    out_kind_q;
	logic [pser_pkg::VALUE_W-1:0]   out_value_q;

	// Pointer RAM: {producer, consumer} per slave.
	logic                           ptr_we;
	logic [2*PTR_W-1:0]             ptr_wdata;
	logic [2*PTR_W-1:0]             ptr_rdata;
	logic [PTR_W-1:0]               ptr_prod;
	logic [PTR_W-1:0]               ptr_cons;
	logic [PTR_W-1:0]               pending;

	// Entry RAM.
	logic                           ent_we;
	logic                           ent_re;
	logic [ENT_AW-1:0]              ent_addr;
	logic [pser_pkg::ENTRY_W-1:0]   ent_rdata;

	// Slot index unit.
	logic                           rem_start;
	logic [PTR_W-1:0]               rem_value;
	logic                           rem_done;
	logic [RD_W-1:0]                rem;

	logic                           in_take;
	logic                           out_load;
	logic                           is_get;
	logic                           bc_last;
	logic [WIDE_W-1:0]              slave_wide;
	logic [WIDE_W-1:0]              cur_wide;

	// A slave is active when it exists, has a mask bit and that bit is set.
	function automatic logic slave_active(input logic [WIDE_W-1:0] s,
			input logic [pser_pkg::MASK_W-1:0] mask);
		slave_active = (s < WIDE_W'(SLAVE_CNT)) && (s < WIDE_W'(pser_pkg::MASK_W)) &&
			mask[s[pser_pkg::SLAVE_W-1:0]];
	endfunction

	assign in_stall   = (state_q != S_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign cfg_ready  = 1'b1;
	assign is_get     = (kind_q == pser_pkg::KIND_GET);
	assign bc_last    = (cur_q == SLV_W'(SLAVE_CNT - 1));
	assign slave_wide = WIDE_W'(slave);
	assign cur_wide   = WIDE_W'(cur_q);
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// A pointer word that was never written reads as zero.
	assign ptr_prod = ptr_vld_q[cur_q] ? ptr_rdata[2*PTR_W-1:PTR_W] : '0;
	assign ptr_cons = ptr_vld_q[cur_q] ? ptr_rdata[PTR_W-1:0] : '0;
	assign pending  = ptr_prod - ptr_cons;

	assign rem_start = (state_q == S_PUSE);
	assign rem_value = is_get ? ptr_cons : ptr_prod;

	assign ent_addr = ENT_AW'(cur_q) * ENT_AW'(RING_DEPTH) + ENT_AW'(rem);
	assign ent_we   = (state_q == S_REM) && rem_done && !is_get;
	assign ent_re   = (state_q == S_REM) && rem_done && is_get;

	// Pointer updates: overflow resync at pointer use, advance after the slot index.
	always_comb begin
		ptr_we    = 1'b0;
		ptr_wdata = {prod_q, cons_q};
		if (state_q == S_PUSE && is_get && ptr_prod != ptr_cons &&
				pending > PTR_W'(RING_DEPTH)) begin
			ptr_we    = 1'b1;
			ptr_wdata = {ptr_prod, ptr_prod - PTR_W'(RING_DEPTH)};
		end else if (state_q == S_REM && rem_done) begin
			ptr_we    = 1'b1;
			ptr_wdata = is_get ? {prod_q, cons_q + 1'b1} : {prod_q + 1'b1, cons_q};
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					case (kind)
						pser_pkg::KIND_POST: begin
							if (slave_active(slave_wide, mask_q)) begin
								state_d = S_PRD;
							end
						end
						pser_pkg::KIND_BCAST: state_d = S_BC;
						pser_pkg::KIND_GET: begin
							state_d = (slave_wide < WIDE_W'(SLAVE_CNT)) ? S_PRD : S_OUT;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_BC: begin
				if (slave_active(cur_wide, mask_q)) begin
					state_d = S_PRD;
				end else if (bc_last) begin
					state_d = S_IDLE;
				end
			end
			S_PRD: state_d = S_PUSE;
			S_PUSE: begin
				if (is_get && (ptr_prod == ptr_cons || pending > PTR_W'(RING_DEPTH))) begin
					state_d = S_OUT;
				end else begin
					state_d = S_REM;
				end
			end
			S_REM: begin
				if (rem_done) begin
					if (is_get) begin
						state_d = S_ERD;
					end else if (kind_q == pser_pkg::KIND_BCAST && !bc_last) begin
						state_d = S_BC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ERD: state_d = S_OUT;
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mask_q      <= '0;
			none_q      <= pser_pkg::CODE_W'(255);
			ovf_q       <= pser_pkg::CODE_W'(15);
			ptr_vld_q   <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			kind_q      <= pser_pkg::KIND_POST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pser_pkg::CFG_ACTIVE_MASK:   mask_q <= cfg_data;
					pser_pkg::CFG_NONE_CODE:     none_q <= cfg_data;
					pser_pkg::CFG_OVERFLOW_CODE: ovf_q  <= cfg_data;
					default: ;
				endcase
			end
			if (ptr_we) begin
				ptr_vld_q[cur_q] <= 1'b1;
			end
			if (in_take) begin
				kind_q <= kind;
				cur_q  <= (kind == pser_pkg::KIND_BCAST) ? '0 : SLV_W'(slave);
			end else if ((state_q == S_BC && !slave_active(cur_wide, mask_q) && !bc_last) ||
					(state_q == S_REM && rem_done && !is_get &&
					kind_q == pser_pkg::KIND_BCAST && !bc_last)) begin
				cur_q <= cur_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			type_q     <= event_type;
			port_q     <= port;
			param_q    <= param;
			res_kind_q <= pser_pkg::RES_EMPTY;
			res_val_q  <= pser_pkg::VALUE_W'(none_q);
		end
		if (state_q == S_PUSE) begin
			prod_q <= ptr_prod;
			cons_q <= ptr_cons;
			if (ptr_prod == ptr_cons) begin
				res_kind_q <= pser_pkg::RES_EMPTY;
				res_val_q  <= pser_pkg::VALUE_W'(none_q);
			end else begin
				res_kind_q <= pser_pkg::RES_OVERFLOW;
				res_val_q  <= pser_pkg::VALUE_W'(ovf_q);
			end
		end
		if (state_q == S_ERD) begin
			res_kind_q <= pser_pkg::RES_ENTRY;
			res_val_q  <= {ent_rdata[pser_pkg::ENTRY_W-1:16], 16'h0000, ent_rdata[15:0]};
		end
		if (out_load) begin
			out_kind_q  <= res_kind_q;
			out_value_q <= res_val_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign out_value   = out_value_q;

	pser_ram #(
		.WIDTH (2 * PTR_W),
		.DEPTH (SLAVE_CNT)
	) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (cur_q),
		.wdata (ptr_wdata),
		.re    (state_q == S_PRD),
		.raddr (cur_q),
		.rdata (ptr_rdata)
	);

	pser_ram #(
		.WIDTH (pser_pkg::ENTRY_W),
		.DEPTH (ENT_DEPTH)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_addr),
		.wdata ({param_q, port_q, type_q}),
		.re    (ent_re),
		.raddr (ent_addr),
		.rdata (ent_rdata)
	);

	pser_slot_rem #(
		.RING_DEPTH (RING_DEPTH)
	) u_slot_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.value  (rem_value),
		.done   (rem_done),
		.rem    (rem)
	);

endmodule
`default_nettype wire
